[hdl/blti_pkg.sv]
// Shared types and constants for the bracket-loop tape interpreter.
`default_nettype none
package blti_pkg;

    localparam int BYTE_W   = 8;
    localparam int CELL_W   = 16;
    localparam int LOOPS_W  = 13;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 32;

    typedef logic [1:0]          mode_t;
    typedef logic [1:0]          status_t;
    typedef logic [BYTE_W-1:0]   byte_t;
    typedef logic [CELL_W-1:0]   cell_t;
    typedef logic [LOOPS_W-1:0]  loops_t;

    // Item modes
    localparam mode_t MODE_APPEND  = 2'd0;
    localparam mode_t MODE_STEP    = 2'd1;
    localparam mode_t MODE_RESTART = 2'd2;
    localparam mode_t MODE_CLEAR   = 2'd3;

    // Run status codes
    localparam status_t ST_RUN   = 2'd0;
    localparam status_t ST_HALT  = 2'd1;
    localparam status_t ST_ERROR = 2'd2;
    localparam status_t ST_FULL  = 2'd3;

    // Program characters
    localparam byte_t CH_OPEN  = 8'h5B;  // '['
    localparam byte_t CH_CLOSE = 8'h5D;  // ']'
    localparam byte_t CH_INC   = 8'h2B;  // '+'
    localparam byte_t CH_DEC   = 8'h2D;  // '-'
    localparam byte_t CH_LEFT  = 8'h3C;  // '<'
    localparam byte_t CH_RIGHT = 8'h3E;  // '>'
    localparam byte_t CH_OUT   = 8'h2E;  // '.'
    localparam byte_t CH_IN    = 8'h2C;  // ','

    localparam loops_t LOOPS_MAX      = 13'd8191;
    localparam cell_t  CELL_MAX_RESET = 16'd259;

    // Register word index (paddr[2])
    localparam logic REG_CELL_MAX = 1'b0;

endpackage
`default_nettype wire

[hdl/blti_cmd_if.sv]
// Command channel: mode, program byte and input byte with valid/ready.
`default_nettype none
interface blti_cmd_if;
    logic              valid;
    logic              ready;
    blti_pkg::mode_t   mode;
    blti_pkg::byte_t   program_byte;
    blti_pkg::byte_t   input_byte;

    modport source (output valid, output mode, output program_byte, output input_byte,
                    input ready);
    modport sink   (input valid, input mode, input program_byte, input input_byte,
                    output ready);
endinterface
`default_nettype wire

[hdl/blti_rsp_if.sv]
// Result channel: one result per command with valid/ready.
`default_nettype none
interface blti_rsp_if;
    logic              valid;
    logic              ready;
    logic              out_valid;
    blti_pkg::byte_t   out_byte;
    logic              input_taken;
    blti_pkg::status_t status;

    modport source (output valid, output out_valid, output out_byte, output input_taken,
                    output status, input ready);
    modport sink   (input valid, input out_valid, input out_byte, input input_taken,
                    input status, output ready);
endinterface
`default_nettype wire

[hdl/bracket_loop_tape_interpreter_core.sv]
// Top level of the bracket-loop tape interpreter: sequencer, program store and tape.
`default_nettype none
// The core runs a bracket-loop tape program one instruction per command transfer.
// Mode 0 appends a byte to the program store, mode 1 executes one instruction,
// mode 2 restarts the run (tape, pointer, counter, loop count, status) and mode 3
// also empties the program. Every command returns exactly one result transfer.
// An append, or a step while halted or in error, goes straight to the result hand-off;
// a plain instruction fetches program byte and tape cell, executes, then hands off
// the result. An opener on a zero cell or a closer with a loop open walks the
// program store one byte per cycle through the shared step adder, from its neighbor
// up to and including its match; an unmatched one walks to the end or the start of
// the program before it reports the error, while an opener that is the last byte
// or a closer with no loop open errors at once. The tape lives in a memory with no
// per-cell reset, so a clearing pass over every cell runs after reset and after
// every restart; no command is taken during it (register writes still are).
// A finished result sits in an output register,
// so the next command is taken while that result waits. cell_max is written at
// byte address 0 of the APB port; it should only change while the core is idle.
module bracket_loop_tape_interpreter_core #(
    parameter int TAPE_CELLS    = 500,
    parameter int PROGRAM_DEPTH = 4096
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [blti_pkg::CFG_AW-1:0]  paddr,
    input  wire logic [blti_pkg::CFG_DW-1:0]  pwdata,
    output logic      [blti_pkg::CFG_DW-1:0]  prdata,
    output logic                              pready,
    blti_cmd_if.sink                          cmd,
    blti_rsp_if.source                        rsp
);
    import blti_pkg::*;

    localparam int AW = $clog2(PROGRAM_DEPTH);      // program store index
    localparam int LW = $clog2(PROGRAM_DEPTH + 1);  // program length / counter
    localparam int TW = $clog2(TAPE_CELLS);         // tape index

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_FSCAN = 3'd3;
    localparam logic [2:0] S_BSCAN = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    // Memories
    byte_t prog_mem [PROGRAM_DEPTH];
    cell_t tape_mem [TAPE_CELLS];
    byte_t prog_rdata_reg;
    cell_t tape_rdata_reg;

    // Control state
    logic [2:0]     state_reg, state_next;
    logic [TW-1:0]  clr_reg, clr_next;
    logic           clr_rsp_reg, clr_rsp_next;
    logic [LW-1:0]  len_reg, len_next;
    logic [LW-1:0]  pc_reg, pc_next;
    logic [TW-1:0]  tp_reg, tp_next;
    loops_t         ol_reg, ol_next;
    status_t        run_reg, run_next;
    cell_t          cell_max_reg;
    logic [LW-1:0]  scan_reg, scan_next;
    logic [LW-1:0]  depth_reg, depth_next;
    byte_t          ibyte_reg, ibyte_next;

    // Pending result and output register
    logic           res_ov_reg, res_ov_next;
    byte_t          res_byte_reg, res_byte_next;
    logic           res_taken_reg, res_taken_next;
    status_t        res_status_reg, res_status_next;
    logic           ov_reg, ov_next;
    logic           o_ov_reg, o_ov_next;
    byte_t          o_byte_reg, o_byte_next;
    logic           o_taken_reg, o_taken_next;
    status_t        o_status_reg, o_status_next;

    // Memory ports
    logic           prog_we;
    logic [AW-1:0]  prog_raddr;
    logic           tape_we;
    logic [TW-1:0]  tape_waddr;
    cell_t          tape_wdata;

    // Shared step unit: +/-1 on the counter or scan pointer, compare to length
    logic [LW-1:0]  step_in;
    logic           step_dec;
    logic [LW-1:0]  step_out;
    logic           at_end;

    logic           step_adv;
    logic           step_err;
    logic           cmd_xfer;
    logic           cfg_wr;
    byte_t          instr;
    cell_t          cur_cell;

    assign step_out = step_dec ? (step_in - LW'(1)) : (step_in + LW'(1));
    assign at_end   = (step_out >= len_reg);

    assign instr    = prog_rdata_reg;
    assign cur_cell = tape_rdata_reg;
    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_xfer  = cmd.valid && cmd.ready;

    assign rsp.valid       = ov_reg;
    assign rsp.out_valid   = o_ov_reg;
    assign rsp.out_byte    = o_byte_reg;
    assign rsp.input_taken = o_taken_reg;
    assign rsp.status      = o_status_reg;

    // APB register: cell_max
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CELL_MAX);
    assign prdata = (paddr[2] == REG_CELL_MAX) ? {{(CFG_DW-CELL_W){1'b0}}, cell_max_reg}
                                               : '0;

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        clr_rsp_next    = clr_rsp_reg;
        len_next        = len_reg;
        pc_next         = pc_reg;
        tp_next         = tp_reg;
        ol_next         = ol_reg;
        run_next        = run_reg;
        scan_next       = scan_reg;
        depth_next      = depth_reg;
        ibyte_next      = ibyte_reg;
        res_ov_next     = res_ov_reg;
        res_byte_next   = res_byte_reg;
        res_taken_next  = res_taken_reg;
        res_status_next = res_status_reg;
        ov_next         = ov_reg;
        o_ov_next       = o_ov_reg;
        o_byte_next     = o_byte_reg;
        o_taken_next    = o_taken_reg;
        o_status_next   = o_status_reg;
        prog_we         = 1'b0;
        prog_raddr      = pc_reg[AW-1:0];
        tape_we         = 1'b0;
        tape_waddr      = tp_reg;
        tape_wdata      = '0;
        step_in         = pc_reg;
        step_dec        = 1'b0;
        step_adv        = 1'b0;
        step_err        = 1'b0;

        // Drop the output once the sink takes it
        if (rsp.valid && rsp.ready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                // Zero one tape cell per cycle
                tape_we    = 1'b1;
                tape_waddr = clr_reg;
                clr_next   = clr_reg + TW'(1);
                if (clr_reg == TW'(TAPE_CELLS - 1))
                begin
                    state_next   = clr_rsp_reg ? S_DONE : S_IDLE;
                    clr_rsp_next = 1'b0;
                end
            end
            S_IDLE:
            begin
                if (cmd_xfer)
                begin
                    res_ov_next    = 1'b0;
                    res_byte_next  = '0;
                    res_taken_next = 1'b0;
                    ibyte_next     = cmd.input_byte;
                    unique case (cmd.mode)
                        MODE_APPEND:
                        begin
                            state_next = S_DONE;
                            if (len_reg < LW'(PROGRAM_DEPTH))
                            begin
                                prog_we         = 1'b1;
                                len_next        = len_reg + LW'(1);
                                res_status_next = run_reg;
                            end
                            else
                            begin
                                res_status_next = ST_FULL;
                            end
                        end
                        MODE_STEP:
                        begin
                            if (run_reg != ST_RUN)
                            begin
                                res_status_next = run_reg;
                                state_next      = S_DONE;
                            end
                            else if (pc_reg >= len_reg)
                            begin
                                run_next        = ST_HALT;
                                res_status_next = ST_HALT;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                // Program byte and tape cell arrive next cycle
                                state_next = S_EXEC;
                            end
                        end
                        MODE_RESTART, MODE_CLEAR:
                        begin
                            if (cmd.mode == MODE_CLEAR)
                            begin
                                len_next = '0;
                            end
                            pc_next         = '0;
                            tp_next         = '0;
                            ol_next         = '0;
                            run_next        = ST_RUN;
                            res_status_next = ST_RUN;
                            clr_next        = '0;
                            clr_rsp_next    = 1'b1;
                            state_next      = S_CLEAR;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_EXEC:
            begin
                unique case (instr)
                    CH_OPEN:
                    begin
                        if (cur_cell != '0)
                        begin
                            if (ol_reg != LOOPS_MAX)
                            begin
                                ol_next = ol_reg + loops_t'(1);
                            end
                            step_adv = 1'b1;
                        end
                        else if (at_end)
                        begin
                            step_err = 1'b1;
                        end
                        else
                        begin
                            // Scan forward for the matching closer
                            prog_raddr = step_out[AW-1:0];
                            scan_next  = step_out;
                            depth_next = '0;
                            state_next = S_FSCAN;
                        end
                    end
                    CH_CLOSE:
                    begin
                        step_dec = 1'b1;
                        if ((ol_reg == '0) || (pc_reg == '0))
                        begin
                            step_err = 1'b1;
                        end
                        else
                        begin
                            // Scan back for the matching opener
                            prog_raddr = step_out[AW-1:0];
                            scan_next  = step_out;
                            depth_next = '0;
                            state_next = S_BSCAN;
                        end
                    end
                    CH_INC:
                    begin
                        tape_we    = 1'b1;
                        tape_wdata = (cur_cell >= cell_max_reg) ? '0 : (cur_cell + cell_t'(1));
                        step_adv   = 1'b1;
                    end
                    CH_DEC:
                    begin
                        tape_we    = 1'b1;
                        tape_wdata = (cur_cell == '0) ? cell_max_reg : (cur_cell - cell_t'(1));
                        step_adv   = 1'b1;
                    end
                    CH_LEFT:
                    begin
                        tp_next  = (tp_reg == '0) ? TW'(TAPE_CELLS - 1) : (tp_reg - TW'(1));
                        step_adv = 1'b1;
                    end
                    CH_RIGHT:
                    begin
                        tp_next  = (tp_reg >= TW'(TAPE_CELLS - 1)) ? '0 : (tp_reg + TW'(1));
                        step_adv = 1'b1;
                    end
                    CH_OUT:
                    begin
                        res_ov_next   = 1'b1;
                        res_byte_next = cur_cell[BYTE_W-1:0];
                        step_adv      = 1'b1;
                    end
                    CH_IN:
                    begin
                        tape_we        = 1'b1;
                        tape_wdata     = {{(CELL_W-BYTE_W){1'b0}}, ibyte_reg};
                        res_taken_next = 1'b1;
                        step_adv       = 1'b1;
                    end
                    default:
                    begin
                        step_adv = 1'b1;
                    end
                endcase
            end
            S_FSCAN:
            begin
                step_in = scan_reg;
                if ((instr == CH_CLOSE) && (depth_reg == '0))
                begin
                    // Resume just past the matching closer
                    step_adv = 1'b1;
                end
                else
                begin
                    if (instr == CH_OPEN)
                    begin
                        depth_next = depth_reg + LW'(1);
                    end
                    else if (instr == CH_CLOSE)
                    begin
                        depth_next = depth_reg - LW'(1);
                    end
                    if (at_end)
                    begin
                        step_err = 1'b1;
                    end
                    else
                    begin
                        prog_raddr = step_out[AW-1:0];
                        scan_next  = step_out;
                    end
                end
            end
            S_BSCAN:
            begin
                step_in  = scan_reg;
                step_dec = 1'b1;
                if ((instr == CH_OPEN) && (depth_reg == '0))
                begin
                    // Land on the opener so it re-tests the cell
                    ol_next         = ol_reg - loops_t'(1);
                    pc_next         = scan_reg;
                    res_status_next = ST_RUN;
                    state_next      = S_DONE;
                end
                else
                begin
                    if (instr == CH_CLOSE)
                    begin
                        depth_next = depth_reg + LW'(1);
                    end
                    else if (instr == CH_OPEN)
                    begin
                        depth_next = depth_reg - LW'(1);
                    end
                    if (scan_reg == '0)
                    begin
                        step_err = 1'b1;
                    end
                    else
                    begin
                        prog_raddr = step_out[AW-1:0];
                        scan_next  = step_out;
                    end
                end
            end
            S_DONE:
            begin
                // Hand the result to the output register once it is free
                if (!ov_reg || rsp.ready)
                begin
                    ov_next       = 1'b1;
                    o_ov_next     = res_ov_reg;
                    o_byte_next   = res_byte_reg;
                    o_taken_next  = res_taken_reg;
                    o_status_next = res_status_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Close out an executed instruction
        if (step_err)
        begin
            run_next        = ST_ERROR;
            res_status_next = ST_ERROR;
            state_next      = S_DONE;
        end
        else if (step_adv)
        begin
            pc_next         = step_out;
            run_next        = at_end ? ST_HALT : ST_RUN;
            res_status_next = at_end ? ST_HALT : ST_RUN;
            state_next      = S_DONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            clr_rsp_reg  <= 1'b0;
            len_reg      <= '0;
            pc_reg       <= '0;
            tp_reg       <= '0;
            ol_reg       <= '0;
            run_reg      <= ST_RUN;
            cell_max_reg <= CELL_MAX_RESET;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            clr_rsp_reg <= clr_rsp_next;
            len_reg     <= len_next;
            pc_reg      <= pc_next;
            tp_reg      <= tp_next;
            ol_reg      <= ol_next;
            run_reg     <= run_next;
            ov_reg      <= ov_next;
            if (cfg_wr)
            begin
                cell_max_reg <= pwdata[CELL_W-1:0];
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        scan_reg       <= scan_next;
        depth_reg      <= depth_next;
        ibyte_reg      <= ibyte_next;
        res_ov_reg     <= res_ov_next;
        res_byte_reg   <= res_byte_next;
        res_taken_reg  <= res_taken_next;
        res_status_reg <= res_status_next;
        o_ov_reg       <= o_ov_next;
        o_byte_reg     <= o_byte_next;
        o_taken_reg    <= o_taken_next;
        o_status_reg   <= o_status_next;
    end

    // Program store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (prog_we)
        begin
            prog_mem[len_reg[AW-1:0]] <= cmd.program_byte;
        end
        prog_rdata_reg <= prog_mem[prog_raddr];
    end

    // Tape: one write, one registered read at the pointer
    always_ff @(posedge clk)
    begin
        if (tape_we)
        begin
            tape_mem[tape_waddr] <= tape_wdata;
        end
        tape_rdata_reg <= tape_mem[tp_reg];
    end

endmodule
`default_nettype wire
